// File: rtl/hid_report_refcount_aggregator_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the report aggregator checkers
// Each macro gives one labelled concurrent assertion, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef HID_REPORT_REFCOUNT_AGGREGATOR_ASSERT_SVH
`define HID_REPORT_REFCOUNT_AGGREGATOR_ASSERT_SVH

// Same-cycle implication
`define HRA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("hra assertion failed");

// Next-cycle implication
`define HRA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hra assertion failed");

`endif

// File: rtl/hra_pkg.sv
// ---------------------------------------------------------------------------
// hra_pkg
// Widths, op codes and limits shared by the report aggregator files.
// ---------------------------------------------------------------------------
`default_nettype none

package hra_pkg;

    localparam int COUNT_W         = 8;
    localparam int KEY_W           = 8;
    localparam int MOD_BITS        = 8;
    localparam int BTN_BITS        = 5;
    localparam int FLAG_BITS       = MOD_BITS + BTN_BITS;
    localparam int FLAG_IDX_W      = 4;
    localparam int MAX_REPORT_KEYS = 6;
    localparam int TOTAL_W         = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

    localparam logic [1:0] OP_KEY   = 2'd0;
    localparam logic [1:0] OP_MOUSE = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

endpackage

`default_nettype wire

// File: rtl/hra_in_if.sv
// ---------------------------------------------------------------------------
// hra_in_if
// Event channel: key, mouse-button or release-all transactions.
// ---------------------------------------------------------------------------
`default_nettype none

interface hra_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic       pressed;
    logic [7:0] keycode;
    logic [7:0] modifier_mask;
    logic [4:0] mouse_mask;

    modport source (output valid, op, pressed, keycode, modifier_mask, mouse_mask,
                    input ready);
    modport sink   (input valid, op, pressed, keycode, modifier_mask, mouse_mask,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/hra_out_if.sv
// ---------------------------------------------------------------------------
// hra_out_if
// Report channel: one keyboard and mouse report per transaction.
// ---------------------------------------------------------------------------
`default_nettype none

interface hra_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] modifiers;
    logic [7:0] report_key_0;
    logic [7:0] report_key_1;
    logic [7:0] report_key_2;
    logic [7:0] report_key_3;
    logic [7:0] report_key_4;
    logic [7:0] report_key_5;
    logic [2:0] live_key_total;
    logic [4:0] mouse_buttons;

    modport source (output valid, modifiers, report_key_0, report_key_1, report_key_2,
                    report_key_3, report_key_4, report_key_5, live_key_total,
                    mouse_buttons, input ready);
    modport sink   (input valid, modifiers, report_key_0, report_key_1, report_key_2,
                    report_key_3, report_key_4, report_key_5, live_key_total,
                    mouse_buttons, output ready);
endinterface

`default_nettype wire

// File: rtl/hra_ram.sv
// ---------------------------------------------------------------------------
// hra_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module hra_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/hra_sat.sv
// ---------------------------------------------------------------------------
// hra_sat
// Shared saturating up/down counter step for slots, modifiers and buttons.
// ---------------------------------------------------------------------------
`default_nettype none

module hra_sat (
    input  wire logic [hra_pkg::COUNT_W-1:0] value,
    input  wire logic                        up,
    output logic      [hra_pkg::COUNT_W-1:0] result
);

    always_comb
    begin
        if (up)
        begin
            result = (value == hra_pkg::COUNT_MAX) ? value : value + 1'b1;
        end
        else
        begin
            result = (value == '0) ? value : value - 1'b1;
        end
    end

endmodule

`default_nettype wire

// File: rtl/hid_report_refcount_aggregator.sv
// ---------------------------------------------------------------------------
// hid_report_refcount_aggregator
// Reference-counted HID keyboard and mouse report builder.
// ---------------------------------------------------------------------------
// Takes one event transaction at a time and returns one report transaction
// per event. Keycode slots live in a RAM (NUM_SLOTS entries) whose one read
// port, together with one shared saturating counter, sets the timing. A key
// action with a nonzero keycode runs a walk of the slots for a match, one
// write, eight modifier steps, a second walk to build the report and a
// publish step. A key action with keycode zero skips the first walk and the
// write, a mouse action runs the button steps, the report walk and the
// publish step, and release-all or an unused op runs only the report walk
// and the publish step. A report still waiting in the output register holds
// the block in its publish step until it is taken. The event side is ready
// again as soon as the report sits in the output register. No clearing pass
// after reset: per-slot valid flops clear at once.
`default_nettype none

module hid_report_refcount_aggregator #(
    parameter int NUM_SLOTS   = 16,
    parameter int REPORT_KEYS = 6
) (
    input  wire logic clk,
    input  wire logic rst_n,
    hra_in_if.sink    evt,
    hra_out_if.source rpt
);

    localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int SLOT_W = hra_pkg::KEY_W + hra_pkg::COUNT_W;
    localparam int NKEYS  = hra_pkg::MAX_REPORT_KEYS;
    localparam int FLG    = hra_pkg::FLAG_BITS;
    localparam int FIW    = hra_pkg::FLAG_IDX_W;
    localparam int CW     = hra_pkg::COUNT_W;
    localparam int KW     = hra_pkg::KEY_W;
    localparam int TW     = hra_pkg::TOTAL_W;

    localparam logic [CNT_W-1:0] SLOT_END  = CNT_W'(NUM_SLOTS);
    localparam logic [TW-1:0]    KEY_LIMIT = TW'(REPORT_KEYS);
    localparam logic [2:0]       MOD_LAST  = 3'(hra_pkg::MOD_BITS - 1);
    localparam logic [2:0]       BTN_LAST  = 3'(hra_pkg::BTN_BITS - 1);
    localparam logic [FIW-1:0]   BTN_BASE  = FIW'(hra_pkg::MOD_BITS);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_SCAN    = 6'b000010,
        ST_SLOT_WR = 6'b000100,
        ST_BITS    = 6'b001000,
        ST_REPORT  = 6'b010000,
        ST_PUBLISH = 6'b100000
    } state_t;

    // control state
    state_t               state_reg,   state_next;
    logic [NUM_SLOTS-1:0] valid_reg,   valid_next;
    logic [CW-1:0]        cnt_reg [FLG];
    logic [CW-1:0]        cnt_next [FLG];
    logic [FLG-1:0]       flags_reg,   flags_next;
    logic [CNT_W-1:0]     rd_cnt_reg,  rd_cnt_next;
    logic                 chk_vld_reg, chk_vld_next;
    logic [2:0]           bit_cnt_reg, bit_cnt_next;
    logic                 match_found_reg, match_found_next;
    logic                 free_found_reg,  free_found_next;
    logic [TW-1:0]        total_reg,   total_next;
    logic                 out_vld_reg, out_vld_next;

    // payload
    logic                 press_reg,     press_next;
    logic [KW-1:0]        key_reg,       key_next;
    logic [7:0]           mask_reg,      mask_next;
    logic [FIW-1:0]       base_reg,      base_next;
    logic [2:0]           limit_reg,     limit_next;
    logic [IDX_W-1:0]     chk_idx_reg,   chk_idx_next;
    logic [IDX_W-1:0]     match_idx_reg, match_idx_next;
    logic [CW-1:0]        match_cnt_reg, match_cnt_next;
    logic [IDX_W-1:0]     free_idx_reg,  free_idx_next;
    logic [KW-1:0]        keys_reg [NKEYS];
    logic [KW-1:0]        keys_next [NKEYS];
    logic [7:0]           out_mod_reg,   out_mod_next;
    logic [KW-1:0]        out_keys_reg [NKEYS];
    logic [KW-1:0]        out_keys_next [NKEYS];
    logic [TW-1:0]        out_total_reg, out_total_next;
    logic [4:0]           out_btn_reg,   out_btn_next;

    // RAM and shared counter
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [SLOT_W-1:0]    ram_wdata;
    logic [SLOT_W-1:0]    ram_rdata;
    logic [CW-1:0]        sat_in;
    logic [CW-1:0]        sat_out;

    logic [KW-1:0]        slot_code;
    logic [CW-1:0]        slot_cnt;
    logic                 slot_live;
    logic [FIW-1:0]       flag_idx;
    logic                 walk_start;

    hra_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (NUM_SLOTS),
        .AW    (IDX_W)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_cnt_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    hra_sat u_sat (
        .value  (sat_in),
        .up     (press_reg),
        .result (sat_out)
    );

    // a slot never written since reset or release-all reads as empty
    assign slot_code = valid_reg[chk_idx_reg] ? ram_rdata[SLOT_W-1:CW] : '0;
    assign slot_cnt  = valid_reg[chk_idx_reg] ? ram_rdata[CW-1:0] : '0;
    assign slot_live = (slot_cnt != '0);
    assign flag_idx  = {1'b0, bit_cnt_reg} + base_reg;

    always_comb
    begin
        state_next       = state_reg;
        valid_next       = valid_reg;
        cnt_next         = cnt_reg;
        flags_next       = flags_reg;
        rd_cnt_next      = rd_cnt_reg;
        chk_vld_next     = chk_vld_reg;
        bit_cnt_next     = bit_cnt_reg;
        match_found_next = match_found_reg;
        free_found_next  = free_found_reg;
        total_next       = total_reg;
        out_vld_next     = out_vld_reg && !rpt.ready;
        press_next       = press_reg;
        key_next         = key_reg;
        mask_next        = mask_reg;
        base_next        = base_reg;
        limit_next       = limit_reg;
        chk_idx_next     = chk_idx_reg;
        match_idx_next   = match_idx_reg;
        match_cnt_next   = match_cnt_reg;
        free_idx_next    = free_idx_reg;
        keys_next        = keys_reg;
        out_mod_next     = out_mod_reg;
        out_keys_next    = out_keys_reg;
        out_total_next   = out_total_reg;
        out_btn_next     = out_btn_reg;
        ram_we           = 1'b0;
        ram_waddr        = match_idx_reg;
        ram_wdata        = '0;
        sat_in           = cnt_reg[flag_idx];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (evt.valid)
                begin
                    press_next       = evt.pressed;
                    key_next         = evt.keycode;
                    bit_cnt_next     = '0;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                    total_next       = '0;
                    for (int k = 0; k < NKEYS; k++)
                    begin
                        keys_next[k] = '0;
                    end
                    priority if (evt.op == hra_pkg::OP_KEY)
                    begin
                        mask_next  = evt.modifier_mask;
                        base_next  = '0;
                        limit_next = MOD_LAST;
                        state_next = (evt.keycode != '0) ? ST_SCAN : ST_BITS;
                    end
                    else if (evt.op == hra_pkg::OP_MOUSE)
                    begin
                        mask_next  = {3'b000, evt.mouse_mask};
                        base_next  = BTN_BASE;
                        limit_next = BTN_LAST;
                        state_next = ST_BITS;
                    end
                    else if (evt.op == hra_pkg::OP_CLEAR)
                    begin
                        valid_next = '0;
                        flags_next = '0;
                        for (int f = 0; f < FLG; f++)
                        begin
                            cnt_next[f] = '0;
                        end
                        state_next = ST_REPORT;
                    end
                    else
                    begin
                        state_next = ST_REPORT;
                    end
                end
            end

            ST_SCAN:
            begin
                chk_vld_next = (rd_cnt_reg != SLOT_END);
                chk_idx_next = rd_cnt_reg[IDX_W-1:0];
                if (rd_cnt_reg != SLOT_END)
                begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
                if (chk_vld_reg)
                begin
                    if (!match_found_reg && slot_live && (slot_code == key_reg))
                    begin
                        match_found_next = 1'b1;
                        match_idx_next   = chk_idx_reg;
                        match_cnt_next   = slot_cnt;
                    end
                    if (!free_found_reg && !slot_live)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = chk_idx_reg;
                    end
                    if (rd_cnt_reg == SLOT_END)
                    begin
                        state_next = ST_SLOT_WR;
                    end
                end
            end

            ST_SLOT_WR:
            begin
                sat_in = match_cnt_reg;
                priority if (match_found_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = match_idx_reg;
                    ram_wdata = (sat_out == '0) ? '0 : {key_reg, sat_out};
                end
                else if (press_reg && free_found_reg)
                begin
                    ram_we                   = 1'b1;
                    ram_waddr                = free_idx_reg;
                    ram_wdata                = {key_reg, CW'(1)};
                    valid_next[free_idx_reg] = 1'b1;
                end
                else
                begin
                    // table full, or release of a key not held: drop
                    ram_we = 1'b0;
                end
                state_next = ST_BITS;
            end

            ST_BITS:
            begin
                if (mask_reg[bit_cnt_reg])
                begin
                    cnt_next[flag_idx]   = sat_out;
                    flags_next[flag_idx] = (sat_out != '0);
                end
                if (bit_cnt_reg == limit_reg)
                begin
                    state_next = ST_REPORT;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg + 1'b1;
                end
            end

            ST_REPORT:
            begin
                chk_vld_next = (rd_cnt_reg != SLOT_END);
                chk_idx_next = rd_cnt_reg[IDX_W-1:0];
                if (rd_cnt_reg != SLOT_END)
                begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
                if (chk_vld_reg)
                begin
                    if (slot_live && (total_reg < KEY_LIMIT))
                    begin
                        keys_next[total_reg] = slot_code;
                        total_next           = total_reg + 1'b1;
                    end
                    if (rd_cnt_reg == SLOT_END)
                    begin
                        state_next = ST_PUBLISH;
                    end
                end
            end

            ST_PUBLISH:
            begin
                // hold until the output register is free or being emptied
                if (!out_vld_reg || rpt.ready)
                begin
                    out_vld_next   = 1'b1;
                    out_mod_next   = flags_reg[hra_pkg::MOD_BITS-1:0];
                    out_btn_next   = flags_reg[FLG-1:hra_pkg::MOD_BITS];
                    out_keys_next  = keys_reg;
                    out_total_next = total_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // restart the slot walk on entry to either walk state
        walk_start = (state_next != state_reg) &&
                     ((state_next == ST_SCAN) || (state_next == ST_REPORT));
        if (walk_start)
        begin
            rd_cnt_next  = '0;
            chk_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            valid_reg       <= '0;
            flags_reg       <= '0;
            rd_cnt_reg      <= '0;
            chk_vld_reg     <= 1'b0;
            bit_cnt_reg     <= '0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            total_reg       <= '0;
            out_vld_reg     <= 1'b0;
            for (int f = 0; f < FLG; f++)
            begin
                cnt_reg[f] <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            valid_reg       <= valid_next;
            cnt_reg         <= cnt_next;
            flags_reg       <= flags_next;
            rd_cnt_reg      <= rd_cnt_next;
            chk_vld_reg     <= chk_vld_next;
            bit_cnt_reg     <= bit_cnt_next;
            match_found_reg <= match_found_next;
            free_found_reg  <= free_found_next;
            total_reg       <= total_next;
            out_vld_reg     <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        press_reg     <= press_next;
        key_reg       <= key_next;
        mask_reg      <= mask_next;
        base_reg      <= base_next;
        limit_reg     <= limit_next;
        chk_idx_reg   <= chk_idx_next;
        match_idx_reg <= match_idx_next;
        match_cnt_reg <= match_cnt_next;
        free_idx_reg  <= free_idx_next;
        keys_reg      <= keys_next;
        out_mod_reg   <= out_mod_next;
        out_keys_reg  <= out_keys_next;
        out_total_reg <= out_total_next;
        out_btn_reg   <= out_btn_next;
    end

    assign evt.ready          = (state_reg == ST_IDLE);
    assign rpt.valid          = out_vld_reg;
    assign rpt.modifiers      = out_mod_reg;
    assign rpt.report_key_0   = out_keys_reg[0];
    assign rpt.report_key_1   = out_keys_reg[1];
    assign rpt.report_key_2   = out_keys_reg[2];
    assign rpt.report_key_3   = out_keys_reg[3];
    assign rpt.report_key_4   = out_keys_reg[4];
    assign rpt.report_key_5   = out_keys_reg[5];
    assign rpt.live_key_total = out_total_reg;
    assign rpt.mouse_buttons  = out_btn_reg;

endmodule

`default_nettype wire

// File: rtl/hra_checker.sv
// ---------------------------------------------------------------------------
// hra_checker
// Port-level checks on the report aggregator, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "hid_report_refcount_aggregator_assert.svh"

module hra_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       evt_valid,
    input wire logic       evt_ready,
    input wire logic       rpt_valid,
    input wire logic       rpt_ready,
    input wire logic [7:0] rpt_modifiers,
    input wire logic [7:0] rpt_report_key_0,
    input wire logic [7:0] rpt_report_key_5,
    input wire logic [2:0] rpt_live_key_total,
    input wire logic [4:0] rpt_mouse_buttons
);

    localparam logic [2:0] TOTAL_LIMIT = 3'(hra_pkg::MAX_REPORT_KEYS);

    // live keycodes are never zero, so the first key shows whether any is live
    `HRA_ASSERT_IMP(a_first_key_vs_total, clk, rst_n, rpt_valid, ((rpt_live_key_total == 3'd0) == (rpt_report_key_0 == 8'd0)))

    // a full report is the only one with a last key filled
    `HRA_ASSERT_IMP(a_total_bound, clk, rst_n, rpt_valid, ((rpt_live_key_total <= TOTAL_LIMIT) && ((rpt_live_key_total == TOTAL_LIMIT) || (rpt_report_key_5 == 8'd0))))

    // an accepted event keeps the block busy for the next cycle at least
    `HRA_ASSERT_NXT(a_busy_after_accept, clk, rst_n, (evt_valid && evt_ready), !evt_ready)

    `HRA_ASSERT_NXT(a_report_held, clk, rst_n, (rpt_valid && !rpt_ready), (rpt_valid && $stable(rpt_modifiers) && $stable(rpt_report_key_0) && $stable(rpt_live_key_total) && $stable(rpt_mouse_buttons)))

endmodule

bind hid_report_refcount_aggregator hra_checker u_hra_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .evt_valid          (evt.valid),
    .evt_ready          (evt.ready),
    .rpt_valid          (rpt.valid),
    .rpt_ready          (rpt.ready),
    .rpt_modifiers      (rpt.modifiers),
    .rpt_report_key_0   (rpt.report_key_0),
    .rpt_report_key_5   (rpt.report_key_5),
    .rpt_live_key_total (rpt.live_key_total),
    .rpt_mouse_buttons  (rpt.mouse_buttons)
);

`default_nettype wire

// File: test/hid_report_refcount_aggregator_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hid_report_refcount_aggregator_tb
// Self-checking bench for the reference-counted keyboard and mouse report
// builder. A directed table walks the reset state, the extremes and each
// special case. Random key, modifier and mouse traffic follows under three
// idle mixes. Every report is checked against a behavioural tracker of the
// slot table and counters, or for pinned rows against the typed-in report.
// ---------------------------------------------------------------------------

module hid_report_refcount_aggregator_tb;
    import hra_pkg::*;

    localparam int         SLOT_COUNT     = 16;
    localparam int         PERIOD_NS      = 10;
    localparam int         SETTLE_CYCLES  = 60;
    localparam int         HOLD_CYCLES    = 400;
    localparam int         ERR_SHOWN      = 10;
    localparam int         POOL_KEYS      = 20;
    localparam int         RAND_PER_MIX   = 270;
    localparam int         SAT_STEPS      = 513;
    localparam int         SAT_PRESSES    = 257;
    localparam logic [1:0] OP_SPARE       = 2'd3;

    typedef struct packed {
        logic [1:0]          op;
        logic                pressed;
        logic [KEY_W-1:0]    keycode;
        logic [MOD_BITS-1:0] mod_mask;
        logic [BTN_BITS-1:0] btn_mask;
    } hid_event_t;

    typedef struct packed {
        logic [MOD_BITS-1:0]                   mods;
        logic [MAX_REPORT_KEYS-1:0][KEY_W-1:0] keys;
        logic [TOTAL_W-1:0]                    total;
        logic [BTN_BITS-1:0]                   buttons;
    } hid_report_t;

    typedef struct packed {
        hid_event_t  ev;
        logic        pinned;
        hid_report_t rpt;
    } stim_row_t;

    localparam int          EV_W     = $bits(hid_event_t);
    localparam int          DIR_ROWS = 24;
    localparam hid_report_t NO_KEYS  = '0;

    // Rows with pinned set carry the report typed in; the rest use the tracker.
    localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
        // unused op and releases with nothing held
        '{'{OP_SPARE, 1'b1, 8'hFF, 8'hFF, 5'h1F}, 1'b1, NO_KEYS},
        '{'{OP_KEY,   1'b0, 8'h04, 8'hFF, 5'h00}, 1'b1, NO_KEYS},
        '{'{OP_MOUSE, 1'b0, 8'h00, 8'h00, 5'h1F}, 1'b1, NO_KEYS},
        // fields foreign to the op must not act; keycode zero leaves the table
        '{'{OP_MOUSE, 1'b1, 8'hFF, 8'hFF, 5'h1F}, 1'b1, '{8'h00, 48'h0, 3'd0, 5'h1F}},
        '{'{OP_KEY,   1'b1, 8'h00, 8'hFF, 5'h1F}, 1'b1, '{8'hFF, 48'h0, 3'd0, 5'h1F}},
        '{'{OP_CLEAR, 1'b1, 8'hFF, 8'hFF, 5'h1F}, 1'b1, NO_KEYS},
        '{'{OP_KEY,   1'b1, 8'hFF, 8'h80, 5'h1F}, 1'b1, '{8'h80, 48'hFF, 3'd1, 5'h00}},
        // seven live keys: the last drops out of the report
        '{'{OP_KEY,   1'b1, 8'h01, 8'h01, 5'h00}, 1'b0, NO_KEYS},
        '{'{OP_KEY,   1'b1, 8'h04, 8'h00, 5'h00}, 1'b0, NO_KEYS},
        '{'{OP_KEY,   1'b1, 8'h05, 8'h00, 5'h00}, 1'b0, NO_KEYS},
        '{'{OP_KEY,   1'b1, 8'h06, 8'h00, 5'h00}, 1'b0, NO_KEYS},
        '{'{OP_KEY,   1'b1, 8'h07, 8'h00, 5'h00}, 1'b0, NO_KEYS},
        '{'{OP_KEY,   1'b1, 8'h08, 8'h00, 5'h00}, 1'b0, NO_KEYS},
        '{'{OP_KEY,   1'b1, 8'h04, 8'h80, 5'h00}, 1'b0, NO_KEYS},
        '{'{OP_KEY,   1'b0, 8'h04, 8'h80, 5'h00}, 1'b0, NO_KEYS},
        // free the second slot and refill it with a new key
        '{'{OP_KEY,   1'b0, 8'h01, 8'h01, 5'h00}, 1'b0, NO_KEYS},
        '{'{OP_KEY,   1'b1, 8'h2A, 8'h00, 5'h00}, 1'b0, NO_KEYS},
        '{'{OP_KEY,   1'b0, 8'h04, 8'h00, 5'h00}, 1'b0, NO_KEYS},
        '{'{OP_MOUSE, 1'b1, 8'h00, 8'h00, 5'h05}, 1'b0, NO_KEYS},
        '{'{OP_MOUSE, 1'b1, 8'h00, 8'h00, 5'h01}, 1'b0, NO_KEYS},
        '{'{OP_MOUSE, 1'b0, 8'h00, 8'h00, 5'h01}, 1'b0, NO_KEYS},
        '{'{OP_MOUSE, 1'b0, 8'h00, 8'h00, 5'h01}, 1'b0, NO_KEYS},
        '{'{OP_SPARE, 1'b0, 8'h00, 8'h00, 5'h00}, 1'b0, NO_KEYS},
        '{'{OP_CLEAR, 1'b0, 8'h00, 8'h00, 5'h00}, 1'b1, NO_KEYS}
    };

    logic clk;
    logic rst_n;

    hra_in_if  evt_if ();
    hra_out_if rpt_if ();

    hid_report_refcount_aggregator u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_if),
        .rpt   (rpt_if)
    );

    // Tracker state
    logic [KEY_W-1:0]   slot_code [SLOT_COUNT];
    logic [COUNT_W-1:0] slot_refs [SLOT_COUNT];
    logic [COUNT_W-1:0] mod_refs  [MOD_BITS];
    logic [COUNT_W-1:0] btn_refs  [BTN_BITS];

    hid_report_t pending_reports [$];
    hid_report_t seen_rpt;
    hid_report_t due_rpt;

    int drops_seen      = 0;
    int sat_seen        = 0;
    int sent_total      = 0;
    int reports_checked = 0;
    int mismatches      = 0;
    int src_idle_pct    = 27;
    int sink_idle_pct   = 74;
    int hold_reqs       = 0;

    initial
    begin
        clk = 1'b0;
        forever #(PERIOD_NS / 2) clk = ~clk;
    end

    initial
    begin
        #(10_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [COUNT_W-1:0] step_refs(logic [COUNT_W-1:0] refs, logic press);
        if (press)
        begin
            if (refs == COUNT_MAX)
            begin
                sat_seen++;
                return refs;
            end
            return refs + 1'b1;
        end
        return (refs == '0) ? refs : refs - 1'b1;
    endfunction

    function automatic void clear_tracker();
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            slot_code[i] = '0;
            slot_refs[i] = '0;
        end
        for (int b = 0; b < MOD_BITS; b++)
            mod_refs[b] = '0;
        for (int b = 0; b < BTN_BITS; b++)
            btn_refs[b] = '0;
    endfunction

    // Apply one event to the tracker and return the report that follows it.
    function automatic hid_report_t track_report(hid_event_t ev);
        hid_report_t rpt;
        int          hit;
        int          placed;
        rpt = '0;
        hit = -1;
        case (ev.op)
            OP_KEY:
            begin
                if (ev.keycode != '0)
                begin
                    for (int i = 0; i < SLOT_COUNT; i++)
                        if (hit < 0 && slot_code[i] == ev.keycode)
                            hit = i;
                    if (hit >= 0)
                    begin
                        slot_refs[hit] = step_refs(slot_refs[hit], ev.pressed);
                        if (slot_refs[hit] == '0)
                            slot_code[hit] = '0;
                    end
                    else if (ev.pressed)
                    begin
                        for (int i = 0; i < SLOT_COUNT; i++)
                            if (hit < 0 && slot_refs[i] == '0)
                                hit = i;
                        if (hit >= 0)
                        begin
                            slot_code[hit] = ev.keycode;
                            slot_refs[hit] = 1;
                        end
                        else
                            drops_seen++;
                    end
                end
                for (int b = 0; b < MOD_BITS; b++)
                    if (ev.mod_mask[b])
                        mod_refs[b] = step_refs(mod_refs[b], ev.pressed);
            end
            OP_MOUSE:
            begin
                for (int b = 0; b < BTN_BITS; b++)
                    if (ev.btn_mask[b])
                        btn_refs[b] = step_refs(btn_refs[b], ev.pressed);
            end
            OP_CLEAR:
                clear_tracker();
            default: ;
        endcase

        placed = 0;
        for (int i = 0; i < SLOT_COUNT; i++)
            if (slot_refs[i] != '0 && slot_code[i] != '0 && placed < MAX_REPORT_KEYS)
            begin
                rpt.keys[placed] = slot_code[i];
                placed++;
            end
        rpt.total = TOTAL_W'(placed);
        for (int b = 0; b < MOD_BITS; b++)
            rpt.mods[b] = (mod_refs[b] != '0);
        for (int b = 0; b < BTN_BITS; b++)
            rpt.buttons[b] = (btn_refs[b] != '0);
        return rpt;
    endfunction

    // Offer one event, hold it until taken, then queue the report it must give.
    task automatic send_event(input hid_event_t ev, input logic pinned,
                              input hid_report_t pin_rpt);
        hid_report_t want;
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            evt_if.valid <= 1'b0;
            repeat ($urandom_range(1, 48)) @(posedge clk);
        end
        evt_if.valid         <= 1'b1;
        evt_if.op            <= ev.op;
        evt_if.pressed       <= ev.pressed;
        evt_if.keycode       <= ev.keycode;
        evt_if.modifier_mask <= ev.mod_mask;
        evt_if.mouse_mask    <= ev.btn_mask;
        @(posedge clk);
        while (!evt_if.ready)
            @(posedge clk);
        want = track_report(ev);
        pending_reports.push_back(pinned ? pin_rpt : want);
        sent_total++;
    endtask

    task automatic drain_reports();
        evt_if.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    // Report side: random back-pressure, plus long hold-offs on request
    initial
    begin : report_sink
        int hold_left;
        int hold_taken;
        hold_left    = 0;
        hold_taken   = 0;
        rpt_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_reqs != hold_taken)
            begin
                hold_taken = hold_reqs;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rpt_if.ready <= 1'b0;
            end
            else
                rpt_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rpt_if.valid && rpt_if.ready)
        begin
            seen_rpt.mods    = rpt_if.modifiers;
            seen_rpt.keys    = {rpt_if.report_key_5, rpt_if.report_key_4, rpt_if.report_key_3,
                                rpt_if.report_key_2, rpt_if.report_key_1, rpt_if.report_key_0};
            seen_rpt.total   = rpt_if.live_key_total;
            seen_rpt.buttons = rpt_if.mouse_buttons;
            reports_checked++;
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= ERR_SHOWN)
                    $display("report %0d arrived with none pending: mods %h keys %h",
                             reports_checked, seen_rpt.mods, seen_rpt.keys);
            end
            else
            begin
                due_rpt = pending_reports.pop_front();
                if (seen_rpt.mods !== due_rpt.mods || seen_rpt.keys !== due_rpt.keys ||
                    seen_rpt.total !== due_rpt.total || seen_rpt.buttons !== due_rpt.buttons)
                begin
                    mismatches++;
                    if (mismatches <= ERR_SHOWN)
                        $display("report %0d: exp mods %h keys %h total %0d btn %h",
                                 reports_checked, due_rpt.mods, due_rpt.keys,
                                 due_rpt.total, due_rpt.buttons,
                                 "\n           got mods %h keys %h total %0d btn %h",
                                 seen_rpt.mods, seen_rpt.keys,
                                 seen_rpt.total, seen_rpt.buttons);
                end
            end
        end
    end

    initial
    begin : stimulus
        hid_event_t       ev;
        logic [KEY_W-1:0] key_pool [POOL_KEYS];
        int               pick;
        int               base;
        int               mix_target;
        logic             burst;
        logic             hold_done;

        rst_n                = 1'b0;
        evt_if.valid         = 1'b0;
        evt_if.op            = OP_KEY;
        evt_if.pressed       = 1'b0;
        evt_if.keycode       = '0;
        evt_if.modifier_mask = '0;
        evt_if.mouse_mask    = '0;
        clear_tracker();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIR_TAB[i])
            send_event(DIR_TAB[i].ev, DIR_TAB[i].pinned, DIR_TAB[i].rpt);
        drain_reports();

        for (int mix = 0; mix < 3; mix++)
        begin
            src_idle_pct  = (mix == 0) ? 27 : (mix == 1) ? 74 : 0;
            sink_idle_pct <= (mix == 0) ? 74 : (mix == 1) ? 27 : 0;
            // distinct keys, more of them than slots, so the table can fill
            base = $urandom_range(1, 190);
            foreach (key_pool[k])
                key_pool[k] = KEY_W'(base + 3 * k);
            key_pool[POOL_KEYS - 1] = 8'hFF;

            if (mix == 2)
            begin
                // drive one slot, all modifiers and all buttons past saturation
                // and back down past zero
                ev = '0;
                ev.op = OP_CLEAR;
                send_event(ev, 1'b0, NO_KEYS);
                for (int k = 0; k < SAT_STEPS; k++)
                begin
                    ev          = '0;
                    ev.op       = OP_KEY;
                    ev.pressed  = (k < SAT_PRESSES);
                    ev.keycode  = key_pool[3];
                    ev.mod_mask = 8'hFF;
                    send_event(ev, 1'b0, NO_KEYS);
                    ev.op       = OP_MOUSE;
                    ev.btn_mask = 5'h1F;
                    send_event(ev, 1'b0, NO_KEYS);
                end
            end

            mix_target = sent_total + RAND_PER_MIX;
            hold_done  = 1'b0;
            while (sent_total < mix_target)
            begin
                if (!hold_done && sent_total >= mix_target - RAND_PER_MIX / 2)
                begin
                    hold_reqs <= hold_reqs + 1;
                    hold_done = 1'b1;
                end
                pick  = $urandom_range(0, 99);
                ev    = hid_event_t'(EV_W'($urandom));
                burst = 1'b0;
                if (pick < 45)
                begin
                    ev.op      = OP_KEY;
                    ev.keycode = key_pool[$urandom_range(0, POOL_KEYS - 1)];
                    ev.pressed = ($urandom_range(0, 99) < 55);
                    if ($urandom_range(0, 1) == 0)
                        ev.mod_mask = 8'h01 << $urandom_range(0, MOD_BITS - 1);
                end
                else if (pick < 55)
                    ev.op = OP_KEY;
                else if (pick < 73)
                begin
                    ev.op      = OP_MOUSE;
                    ev.pressed = ($urandom_range(0, 99) < 55);
                    if ($urandom_range(0, 1) == 0)
                        ev.btn_mask = 5'h01 << $urandom_range(0, BTN_BITS - 1);
                end
                else if (pick < 83)
                begin
                    ev.op      = OP_KEY;
                    ev.keycode = '0;
                end
                else if (pick < 85)
                    ev.op = OP_CLEAR;
                else if (pick < 88)
                    ev.op = OP_SPARE;
                else if (pick < 92)
                begin
                    // press a run of distinct keys until the table overflows
                    burst = 1'b1;
                    for (int k = 0; k < 18; k++)
                    begin
                        ev          = '0;
                        ev.op       = OP_KEY;
                        ev.pressed  = 1'b1;
                        ev.keycode  = key_pool[k];
                        send_event(ev, 1'b0, NO_KEYS);
                    end
                end
                else
                begin
                    ev.op      = OP_KEY;
                    ev.pressed = 1'b0;
                    ev.keycode = key_pool[$urandom_range(0, POOL_KEYS - 1)];
                end
                if (!burst)
                    send_event(ev, 1'b0, NO_KEYS);
            end
            drain_reports();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Checked %0d reports for %0d events: %0d table rows, three idle mixes, %0d-cycle stalls.",
                 reports_checked, sent_total, DIR_ROWS, HOLD_CYCLES);
        $display("Table-full drops %0d, presses held at the count ceiling %0d, mismatches %0d.",
                 drops_seen, sat_seen, mismatches);
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/hra_pkg.sv
rtl/hra_in_if.sv
rtl/hra_out_if.sv
rtl/hra_ram.sv
rtl/hra_sat.sv
rtl/hid_report_refcount_aggregator.sv
rtl/hra_checker.sv
test/hid_report_refcount_aggregator_tb.sv
